// ----- hdl/ppser_pkg.sv -----
// Shared types and constants for the palette pixel serializer.
package ppser_pkg;

  localparam int unsigned PalEntries = 16;
  localparam int unsigned PalIdxW    = $clog2(PalEntries);
  localparam int unsigned PalEntryW  = 4;
  localparam int unsigned DataW      = 8;
  localparam int unsigned RgbW       = 3;
  localparam int unsigned RepW       = 3;
  localparam int unsigned ModeW      = 8;
  localparam int unsigned PixIdxW    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Fields of the control byte
  localparam int unsigned ModeCplLsb  = 2;
  localparam int unsigned ModeFastBit = 4;

  // Chars-per-line codes
  localparam logic [1:0] CplNone = 2'd0;
  localparam logic [1:0] CplLow  = 2'd1;
  localparam logic [1:0] CplMid  = 2'd2;
  localparam logic [1:0] CplHigh = 2'd3;

  // Input opcodes
  localparam logic OpPalWrite = 1'b0;
  localparam logic OpDisplay  = 1'b1;

  // Horizontal repeat counts
  localparam logic [RepW-1:0] Rep1 = 3'd1;
  localparam logic [RepW-1:0] Rep2 = 3'd2;
  localparam logic [RepW-1:0] Rep4 = 3'd4;

  typedef enum logic [2:0] {
    CMD_PAL_WRITE,
    CMD_MONO,      // 8 pixels, black or white
    CMD_PAL8,      // 8 pixels, one bit each
    CMD_PAL4,      // 4 pixels, two bits each
    CMD_PAL2       // 2 pixels, four bits each
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [RepW-1:0]  rep;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

// ----- hdl/ppser_front.sv -----
// Front end: control register; each request becomes a command or is dropped.
module ppser_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ppser_pkg::ModeW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [ppser_pkg::DataW-1:0] data_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output ppser_pkg::cmd_t            q_cmd_o
);

  logic [ppser_pkg::ModeW-1:0] mode_control_q, mode_control_d;
  logic [1:0]                  cpl;
  logic                        fast;
  logic                        drop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_control_d = mode_control_q;
    if (cfg_valid_i) begin
      mode_control_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_control_q <= '0;
    end else begin
      mode_control_q <= mode_control_d;
    end
  end

  assign cpl  = mode_control_q[ppser_pkg::ModeCplLsb +: 2];
  assign fast = mode_control_q[ppser_pkg::ModeFastBit];

  // Classify the request
  always_comb begin
    q_cmd_o.data = data_i;
    q_cmd_o.kind = ppser_pkg::CMD_PAL_WRITE;
    q_cmd_o.rep  = ppser_pkg::Rep1;
    drop         = 1'b0;
    if (op_i == ppser_pkg::OpDisplay) begin
      case (cpl)
        ppser_pkg::CplHigh: begin
          q_cmd_o.kind = ppser_pkg::CMD_MONO;
          q_cmd_o.rep  = ppser_pkg::Rep1;
        end
        ppser_pkg::CplMid: begin
          q_cmd_o.kind = fast ? ppser_pkg::CMD_PAL4 : ppser_pkg::CMD_PAL8;
          q_cmd_o.rep  = ppser_pkg::Rep2;
        end
        ppser_pkg::CplLow: begin
          q_cmd_o.kind = fast ? ppser_pkg::CMD_PAL2 : ppser_pkg::CMD_PAL4;
          q_cmd_o.rep  = ppser_pkg::Rep4;
        end
        default: begin
          drop = 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  // Drop display bytes with no matching mode
  assign q_push_o   = in_valid_i && !q_full_i && !drop;

endmodule

// ----- hdl/ppser_queue.sv -----
// Short command queue between the front and back ends.
module ppser_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppser_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ppser_pkg::cmd_t head_o
);

  ppser_pkg::cmd_t                      mem_q [ppser_pkg::QueueDepth];
  logic [ppser_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ppser_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ppser_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                                 do_push, do_pop;

  assign full_o  = (count_q == ppser_pkg::QueueCntW'(ppser_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ppser_pkg::QueuePtrW'(ppser_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ppser_pkg::QueuePtrW'(ppser_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/ppser_back.sv -----
// Back end: palette table, pixel sequencer and output register.
module ppser_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  ppser_pkg::cmd_t             q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ppser_pkg::RgbW-1:0]  pixel_rgb_o,
  output logic [ppser_pkg::RepW-1:0]  repeat_count_o,
  output logic                        last_o
);

  logic [ppser_pkg::PalEntryW-1:0] palette_q [ppser_pkg::PalEntries];
  logic [ppser_pkg::PixIdxW-1:0]   pix_q, pix_d;
  logic                            out_valid_q, out_valid_d;
  logic [ppser_pkg::RgbW-1:0]      rgb_q;
  logic [ppser_pkg::RepW-1:0]      rep_q;
  logic                            last_q;

  logic                            advance;
  logic                            is_write;
  logic                            is_display;
  logic                            emit;
  logic                            pix_last;
  logic [ppser_pkg::PalIdxW-1:0]   pal_idx;
  logic [ppser_pkg::RgbW-1:0]      pix_rgb;
  logic [ppser_pkg::PalIdxW-1:0]   wr_idx;
  logic [ppser_pkg::DataW-1:0]     d;
  logic [1:0]                      v;
  logic [ppser_pkg::PalEntryW-1:0] entry;

  assign d          = q_head_i.data;
  assign is_write   = !q_empty_i && (q_head_i.kind == ppser_pkg::CMD_PAL_WRITE);
  assign is_display = !q_empty_i && (q_head_i.kind != ppser_pkg::CMD_PAL_WRITE);
  assign advance    = !out_valid_q || out_ready_i;
  assign emit       = is_display && advance;
  assign wr_idx     = d[ppser_pkg::DataW-1 -: ppser_pkg::PalIdxW];

  // Pick the pixel bits and palette index for the current position
  always_comb begin
    pal_idx  = '0;
    v        = {d[3'(7 - pix_q)], d[3'(3 - pix_q)]};
    pix_last = 1'b0;
    case (q_head_i.kind)
      ppser_pkg::CMD_MONO: begin
        pix_last = (pix_q == 3'd7);
      end
      ppser_pkg::CMD_PAL8: begin
        pal_idx  = {d[3'(7 - pix_q)], 3'b000};
        pix_last = (pix_q == 3'd7);
      end
      ppser_pkg::CMD_PAL4: begin
        pal_idx  = 4'd4 + {1'b0, v, 1'b0};
        pix_last = (pix_q == 3'd3);
      end
      ppser_pkg::CMD_PAL2: begin
        pal_idx  = {d[3'(7 - pix_q)], d[3'(5 - pix_q)],
                    d[3'(3 - pix_q)], d[3'(1 - pix_q)]};
        pix_last = (pix_q == 3'd1);
      end
      default: begin
        pix_last = 1'b1;
      end
    endcase
  end

  assign entry = palette_q[pal_idx];

  always_comb begin
    if (q_head_i.kind == ppser_pkg::CMD_MONO) begin
      pix_rgb = {ppser_pkg::RgbW{d[3'(7 - pix_q)]}};
    end else begin
      // Colour bits are active low in the palette entry
      pix_rgb = ~entry[ppser_pkg::RgbW-1:0];
    end
  end

  assign q_pop_o = is_write || (emit && pix_last);

  always_comb begin
    pix_d = pix_q;
    if (emit) begin
      pix_d = pix_last ? '0 : pix_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ppser_pkg::PalEntries; i++) begin
        palette_q[i] <= '0;
      end
    end else begin
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
      if (is_write) begin
        palette_q[wr_idx] <= d[ppser_pkg::PalEntryW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rgb_q  <= pix_rgb;
      rep_q  <= q_head_i.rep;
      last_q <= pix_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_rgb_o    = rgb_q;
  assign repeat_count_o = rep_q;
  assign last_o         = last_q;

endmodule

// ----- hdl/palette_pixel_serializer.sv -----
// Top level of the palette pixel serializer.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i and data_i. A palette
//   write (op_i low) stores data_i[3:0] at entry data_i[7:4]. A display byte
//   (op_i high) is cut into 8, 4 or 2 logical pixels by the control register.
//   The config channel (cfg_valid_i/cfg_ready_o) writes the control byte; it
//   is always ready and must only be written while the block is idle.
//   Output channel (out_valid_o/out_ready_i) gives one pixel per beat with
//   pixel_rgb_o, repeat_count_o and last_o (set on a byte's final pixel).
//   A display byte is written into the queue, and its first pixel leaves
//   through the output register. The back-end sequencer emits one pixel per
//   cycle while the receiver takes them, so a byte yields 8, 4 or 2 pixels.
//   A two-entry queue lets the front take requests while pixels drain.
//   Reset clears the control register, the queue, and all palette entries
//   (unwritten entries read as zero, giving white). When the receiver stalls
//   the output register holds, the sequencer waits and the queue fills, after
//   which in_ready_o drops.
module palette_pixel_serializer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  pixel_rgb_o,
  output logic [2:0]  repeat_count_o,
  output logic        last_o
);

  ppser_pkg::cmd_t push_cmd;
  ppser_pkg::cmd_t head_cmd;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  ppser_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_i      (data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  ppser_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  ppser_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (head_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_rgb_o    (pixel_rgb_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o)
  );

endmodule

// ----- dv/tb_palette_pixel_serializer.sv -----
// Testbench for the palette pixel serializer: directed and random requests checked per pixel.
`timescale 1ns / 1ps

module tb_palette_pixel_serializer;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned SettleLimit = 5000;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned RandPhases  = 8;

  typedef struct packed {
    logic [ppser_pkg::RgbW-1:0] rgb;
    logic [ppser_pkg::RepW-1:0] rep;
    logic                       last;
  } pixel_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [ppser_pkg::ModeW-1:0] cfg_data_i     = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic                        op_i           = ppser_pkg::OpPalWrite;
  logic [ppser_pkg::DataW-1:0] data_i         = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [ppser_pkg::RgbW-1:0]  pixel_rgb_o;
  logic [ppser_pkg::RepW-1:0]  repeat_count_o;
  logic                        last_o;

  logic [ppser_pkg::PalEntryW-1:0] palette_model [ppser_pkg::PalEntries];
  logic [ppser_pkg::ModeW-1:0]     mode_model = '0;
  pixel_t                          expected_pixels [$];
  int                              mismatch_count = 0;
  bit                              tx_idle_on     = 1'b1;
  bit                              rx_idle_on     = 1'b1;
  int                              rx_hold_cycles = 0;

  palette_pixel_serializer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .data_i         (data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_rgb_o    (pixel_rgb_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [ppser_pkg::ModeW-1:0] mode_of(logic [1:0] cpl, logic fast);
    logic [ppser_pkg::ModeW-1:0] m;
    m = '0;
    m[ppser_pkg::ModeCplLsb +: 2] = cpl;
    m[ppser_pkg::ModeFastBit]     = fast;
    return m;
  endfunction

  function automatic logic [ppser_pkg::RgbW-1:0] entry_colour(
    logic [ppser_pkg::PalIdxW-1:0] idx
  );
    return ~palette_model[idx][ppser_pkg::RgbW-1:0];
  endfunction

  // Work out the pixels one accepted request produces and queue them.
  task automatic predict_pixels(input logic op, input logic [ppser_pkg::DataW-1:0] data);
    logic [1:0]                    cpl;
    logic                          fast;
    int                            npix;
    logic [ppser_pkg::RepW-1:0]    rep;
    logic [ppser_pkg::PalIdxW-1:0] idx;
    logic [1:0]                    pair;
    pixel_t                        px;
    cpl  = mode_model[ppser_pkg::ModeCplLsb +: 2];
    fast = mode_model[ppser_pkg::ModeFastBit];
    npix = 0;
    if (op == ppser_pkg::OpPalWrite) begin
      palette_model[data[7:4]] = data[3:0];
    end else begin
      if (cpl == ppser_pkg::CplHigh) begin
        npix = 8;
        rep  = ppser_pkg::Rep1;
      end else if (cpl == ppser_pkg::CplMid && !fast) begin
        npix = 8;
        rep  = ppser_pkg::Rep2;
      end else if (cpl == ppser_pkg::CplLow && fast) begin
        npix = 2;
        rep  = ppser_pkg::Rep4;
      end else if (cpl != ppser_pkg::CplNone) begin
        npix = 4;
        rep  = (cpl == ppser_pkg::CplMid) ? ppser_pkg::Rep2 : ppser_pkg::Rep4;
      end
      for (int k = 0; k < npix; k++) begin
        if (cpl == ppser_pkg::CplHigh) begin
          px.rgb = data[7-k] ? 3'd7 : 3'd0;
        end else if (npix == 8) begin
          idx    = {data[7-k], 3'b000};
          px.rgb = entry_colour(idx);
        end else if (npix == 2) begin
          idx    = {data[7-k], data[5-k], data[3-k], data[1-k]};
          px.rgb = entry_colour(idx);
        end else begin
          pair   = {data[7-k], data[3-k]};
          idx    = 4'd4 + {1'b0, pair, 1'b0};
          px.rgb = entry_colour(idx);
        end
        px.rep  = rep;
        px.last = (k == npix - 1);
        expected_pixels.push_back(px);
      end
    end
  endtask

  function automatic void note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Check every accepted pixel against the oldest expectation.
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected pixel rgb", -1, int'(pixel_rgb_o));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_rgb_o !== want.rgb)
          note_mismatch("pixel_rgb", int'(want.rgb), int'(pixel_rgb_o));
        if (repeat_count_o !== want.rep)
          note_mismatch("repeat_count", int'(want.rep), int'(repeat_count_o));
        if (last_o !== want.last)
          note_mismatch("last", int'(want.last), int'(last_o));
      end
    end
  end

  // Receiver: random stalls per pixel, or one long hold when asked.
  initial begin : pixel_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one request; keep valid high straight into the next one when there is no gap.
  task automatic send_request(input logic op, input logic [ppser_pkg::DataW-1:0] data);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    data_i     <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixels(op, data);
  endtask

  // Drop valid, wait for every pixel, then let the pipeline clear with no requests offered.
  task automatic settle_block();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < SettleLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [ppser_pkg::ModeW-1:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_model = value;
  endtask

  task automatic test_no_mode();
    send_request(ppser_pkg::OpDisplay, 8'h00);
    send_request(ppser_pkg::OpDisplay, 8'hFF);
    write_mode(8'hE3);
    send_request(ppser_pkg::OpDisplay, 8'h5A);
  endtask

  task automatic test_unwritten_white();
    write_mode(mode_of(ppser_pkg::CplMid, 1'b0));
    send_request(ppser_pkg::OpDisplay, 8'h00);
    send_request(ppser_pkg::OpDisplay, 8'hFF);
  endtask

  task automatic test_mono();
    write_mode(mode_of(ppser_pkg::CplHigh, 1'b0));
    send_request(ppser_pkg::OpDisplay, 8'hA5);
    write_mode(8'hFF);
    send_request(ppser_pkg::OpDisplay, 8'h5A);
  endtask

  task automatic test_palette_modes();
    send_request(ppser_pkg::OpPalWrite, 8'h0F);
    send_request(ppser_pkg::OpPalWrite, 8'h8A);
    send_request(ppser_pkg::OpPalWrite, 8'h41);
    send_request(ppser_pkg::OpPalWrite, 8'h62);
    send_request(ppser_pkg::OpPalWrite, 8'hA5);
    send_request(ppser_pkg::OpPalWrite, 8'hFC);
    write_mode(mode_of(ppser_pkg::CplMid, 1'b0));
    send_request(ppser_pkg::OpDisplay, 8'h96);
    write_mode(mode_of(ppser_pkg::CplMid, 1'b1));
    send_request(ppser_pkg::OpDisplay, 8'h96);
    write_mode(mode_of(ppser_pkg::CplLow, 1'b1));
    send_request(ppser_pkg::OpDisplay, 8'h3C);
    write_mode(mode_of(ppser_pkg::CplLow, 1'b0));
    send_request(ppser_pkg::OpDisplay, 8'hC3);
  endtask

  // Random phases: new control byte each phase, mixed palette writes and display bytes.
  task automatic test_random_traffic();
    logic [ppser_pkg::ModeW-1:0] mode;
    int                          nitems;
    for (int phase = 0; phase < RandPhases; phase++) begin
      mode = ppser_pkg::ModeW'($urandom_range(0, 255));
      if (phase == 3)
        mode[ppser_pkg::ModeCplLsb +: 2] = ppser_pkg::CplNone;
      else if (mode[ppser_pkg::ModeCplLsb +: 2] == ppser_pkg::CplNone)
        mode[ppser_pkg::ModeCplLsb +: 2] = 2'($urandom_range(1, 3));
      write_mode(mode);
      tx_idle_on = (phase % 3) != 1;
      rx_idle_on = (phase % 4) != 2;
      nitems = (phase == 3) ? 15 : 35;
      for (int i = 0; i < nitems; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_request(ppser_pkg::OpPalWrite, ppser_pkg::DataW'($urandom_range(0, 255)));
        else
          send_request(ppser_pkg::OpDisplay, ppser_pkg::DataW'($urandom_range(0, 255)));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the receiver off while requests keep coming, so the queue fills and input stalls.
  task automatic test_output_stall();
    write_mode(mode_of(ppser_pkg::CplMid, 1'b0));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = LongHold;
    for (int i = 0; i < 12; i++)
      send_request(ppser_pkg::OpDisplay, ppser_pkg::DataW'($urandom_range(0, 255)));
    settle_block();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : run_tests
    foreach (palette_model[i]) palette_model[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_mode();
    test_unwritten_white();
    test_mono();
    test_palette_modes();
    test_random_traffic();
    test_output_stall();
    settle_block();
    if (expected_pixels.size() != 0) begin
      $display("%0d pixels never arrived", expected_pixels.size());
      mismatch_count += expected_pixels.size();
    end
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ppser_pkg.sv
hdl/ppser_front.sv
hdl/ppser_queue.sv
hdl/ppser_back.sv
hdl/palette_pixel_serializer.sv
dv/tb_palette_pixel_serializer.sv
